// ----- hdl/sga_pkg.sv -----
// Shared types and constants for the softened gravity accumulator.
// No dependencies; imported by sga_core, the top level and the testbench.
`default_nettype none
package sga_pkg;

  // fixed field widths
  localparam int MASS_W   = 32;
  localparam int EPS_W    = 32;
  localparam int ACC_W    = 64;
  // softening_sq is Q16.16, R is Q32.32
  localparam int EPS_SH   = 16;
  // numerator scale so the quotient lands in Q32.32
  localparam int FRAC_SH  = 48;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SQR    = 9'b000000010,
    S_ROOT   = 9'b000000100,
    S_DEN    = 9'b000001000,
    S_MULM   = 9'b000010000,
    S_SATCHK = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_ACCUM  = 9'b010000000,
    S_FIN    = 9'b100000000
  } sga_state_t;

  // core status toward the stream wrapper
  typedef struct packed {
    logic busy;
    logic done;
    logic last;
  } sga_status_t;

endpackage
`default_nettype wire

// ----- hdl/sga_alu.sv -----
// Shared wide add / subtract unit with unsigned compare.
// Used by sga_core for multiply, square root and divide steps.
`default_nettype none
module sga_alu #(
  parameter int W = 128
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] y,
  output logic              ge
);
  logic [W:0] s;

  // one adder: a + b, or a + ~b + 1 for subtract
  always_comb begin
    s  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    y  = s[W-1:0];
    ge = s[W];
  end
endmodule
`default_nettype wire

// ----- hdl/sga_core.sv -----
// Sequencer and datapath: squares, integer square root, denominator,
// per-axis restoring divide and saturating sums. Depends on sga_pkg, sga_alu.
`default_nettype none
module sga_core #(
  parameter int CW = 32,
  parameter int SW = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [2:0][CW-1:0]           tgt,
  input  wire logic [2:0][CW-1:0]           src,
  input  wire logic [sga_pkg::MASS_W-1:0]   mass_in,
  input  wire logic                         first_in,
  input  wire logic                         last_in,
  input  wire logic [sga_pkg::EPS_W-1:0]    softening_sq,
  input  wire logic                         out_free,
  output sga_pkg::sga_status_t              status,
  output logic signed [SW-1:0]              sum_x,
  output logic signed [SW-1:0]              sum_y,
  output logic signed [SW-1:0]              sum_z
);
  import sga_pkg::*;

  localparam int DW    = CW + 1;
  localparam int RW0   = (2*CW + 2 > EPS_W + EPS_SH + 1) ? 2*CW + 2 : EPS_W + EPS_SH + 1;
  localparam int RW    = RW0 + 1;
  localparam int SQW   = (RW + 1) / 2;
  localparam int DENW  = RW + SQW;
  localparam int PW    = MASS_W + DW;
  localparam int NUMW  = PW + FRAC_SH;
  localparam int W     = (NUMW > DENW + 2) ? NUMW : DENW + 2;
  localparam int QW    = SW - 1;
  localparam int MPW0  = (DW > SQW) ? DW : SQW;
  localparam int MPW   = (MPW0 > MASS_W) ? MPW0 : MASS_W;
  localparam int MC0   = (MPW > QW) ? MPW : QW;
  localparam int CNTW  = $clog2(MC0 + 1);

  sga_state_t          state;
  logic [CNTW-1:0]     cnt;
  logic [1:0]          axis;
  logic [2:0][DW-1:0]  ad;
  logic [2:0]          neg;
  logic [MASS_W-1:0]   mass;
  logic                last_f;
  logic [W-1:0]        acc;
  logic [W-1:0]        mcand;
  logic [MPW-1:0]      mplier;
  logic [RW-1:0]       rt;
  logic [RW-1:0]       one;
  logic [RW-1:0]       rreg;
  logic [DENW-1:0]     den;
  logic [QW-1:0]       nlo;
  logic [QW-1:0]       q;
  logic [QW-1:0]       mag;
  logic signed [SW-1:0] sums [3];

  logic [W-1:0]        alu_a, alu_b, alu_y;
  logic                alu_sub, alu_ge;
  logic [W-1:0]        mul_val;
  logic [RW-1:0]       rt_nx;
  logic [NUMW-1:0]     numw;
  logic [2:0][DW-1:0]  ad_in;
  logic [2:0]          neg_in;
  logic [DW-1:0]       ad_nxt;
  logic signed [SW-1:0] term, sum_sel, sat_val;
  logic signed [SW:0]  sum_w;
  logic signed [CW:0]  dd;

  sga_alu #(.W(W)) u_alu (
    .a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y), .ge(alu_ge)
  );

  // differences and magnitudes at item capture
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd        = {src[i][CW-1], src[i]} - {tgt[i][CW-1], tgt[i]};
      neg_in[i] = dd[CW];
      ad_in[i]  = dd[CW] ? DW'(-dd) : DW'(dd);
    end
  end

  // shared unit operand select
  always_comb begin
    alu_a   = acc;
    alu_b   = mcand;
    alu_sub = 1'b0;
    unique case (state)
      S_ROOT: begin
        alu_b   = W'(rt | one);
        alu_sub = 1'b1;
      end
      S_SATCHK: begin
        alu_b   = W'(den);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {acc[W-2:0], nlo[QW-1]};
        alu_b   = W'(den);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // step helpers
  always_comb begin
    mul_val = mplier[0] ? alu_y : acc;
    rt_nx   = alu_ge ? ((rt >> 1) | one) : (rt >> 1);
    numw    = {mul_val[PW-1:0], {FRAC_SH{1'b0}}};
    ad_nxt  = (axis == 2'd0) ? ad[1] : ad[2];
  end

  // signed term and saturating add
  always_comb begin
    term    = neg[axis] ? -SW'(mag) : SW'(mag);
    sum_sel = sums[axis];
    sum_w   = {sum_sel[SW-1], sum_sel} + {term[SW-1], term};
    if (sum_w[SW] != sum_w[SW-1]) begin
      sat_val = sum_w[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_val = sum_w[SW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= '0;
      for (int i = 0; i < 3; i++) sums[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ad     <= ad_in;
            neg    <= neg_in;
            mass   <= mass_in;
            last_f <= last_in;
            if (first_in) begin
              for (int i = 0; i < 3; i++) sums[i] <= '0;
            end
            acc    <= W'(softening_sq) << EPS_SH;
            mcand  <= W'(ad_in[0]);
            mplier <= MPW'(ad_in[0]);
            cnt    <= '0;
            axis   <= '0;
            state  <= S_SQR;
          end
        end
        // R = eps << 16 + sum of squares, shift-add
        S_SQR: begin
          acc    <= mul_val;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CNTW'(DW-1)) begin
            cnt <= '0;
            if (axis == 2'd2) begin
              rreg  <= mul_val[RW-1:0];
              rt    <= '0;
              one   <= RW'(1) << (2*(SQW-1));
              state <= (mul_val[RW-1:0] == '0) ? S_FIN : S_ROOT;
            end else begin
              axis   <= axis + 1'b1;
              mcand  <= W'(ad_nxt);
              mplier <= MPW'(ad_nxt);
            end
          end
        end
        // floor(sqrt(R)), one bit per cycle
        S_ROOT: begin
          if (alu_ge) acc <= alu_y;
          rt  <= rt_nx;
          one <= one >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(SQW-1)) begin
            cnt    <= '0;
            acc    <= '0;
            mcand  <= W'(rreg);
            mplier <= MPW'(rt_nx[SQW-1:0]);
            state  <= S_DEN;
          end
        end
        // den = R * S
        S_DEN: begin
          acc    <= mul_val;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CNTW'(SQW-1)) begin
            cnt    <= '0;
            den    <= mul_val[DENW-1:0];
            axis   <= '0;
            acc    <= '0;
            mcand  <= W'(ad[0]);
            mplier <= MPW'(mass);
            state  <= S_MULM;
          end
        end
        // m * |D|
        S_MULM: begin
          acc    <= mul_val;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CNTW'(MASS_W-1)) begin
            cnt   <= '0;
            acc   <= W'(numw[NUMW-1:QW]);
            nlo   <= numw[QW-1:0];
            state <= S_SATCHK;
          end
        end
        // quotient too large for the cap: saturate at once
        S_SATCHK: begin
          if (alu_ge) begin
            mag   <= {QW{1'b1}};
            state <= S_ACCUM;
          end else begin
            q     <= '0;
            state <= S_DIV;
          end
        end
        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          acc <= alu_ge ? alu_y : alu_a;
          nlo <= nlo << 1;
          q   <= {q[QW-2:0], alu_ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(QW-1)) begin
            cnt   <= '0;
            mag   <= {q[QW-2:0], alu_ge};
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          sums[axis] <= sat_val;
          if (axis == 2'd2) begin
            state <= S_FIN;
          end else begin
            axis   <= axis + 1'b1;
            acc    <= '0;
            mcand  <= W'(ad_nxt);
            mplier <= MPW'(mass);
            state  <= S_MULM;
          end
        end
        S_FIN: begin
          if (!last_f || out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    status.busy = (state != S_IDLE);
    status.done = (state == S_FIN);
    status.last = last_f;
    sum_x       = sums[0];
    sum_y       = sums[1];
    sum_z       = sums[2];
  end
endmodule
`default_nettype wire

// ----- hdl/softened_gravity_accumulator.sv -----
// Each item runs the squares, a bit-serial square root and the denominator, then per axis a
// multiply by mass and a divide into a saturating sum; a saturated axis skips its divide and a
// zero softened distance ends after the squares. One shared add/subtract unit does the
// shift-add multiplies, bit-serial square root and restoring divides. A new item is taken
// only while the core is idle; a result waits in the output register while the next item
// runs. Sync reset (rst high) clears sums, softening_sq, valid. Uses sga_core.
`default_nettype none
module softened_gravity_accumulator #(
  parameter int COORD_WIDTH = 32,
  parameter int SUM_WIDTH   = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_wr_en,
  input  wire logic [sga_pkg::EPS_W-1:0] cfg_wr_data,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // target_x, target_y, target_z, src_x, src_y, src_z, src_mass, zero pad
  input  wire logic [((6*COORD_WIDTH+sga_pkg::MASS_W+7)/8)*8-1:0] s_axis_tdata,
  // first
  input  wire logic s_axis_tuser,
  input  wire logic s_axis_tlast,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // acc_x, acc_y, acc_z
  output logic [3*sga_pkg::ACC_W-1:0] m_axis_tdata
);
  import sga_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [EPS_W-1:0]       softening_sq;
  logic [2:0][CW-1:0]     tgt, src;
  logic                   out_free, start;
  sga_status_t            st;
  logic signed [SUM_WIDTH-1:0] sx, sy, sz;

  // field unpack
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tgt[i] = s_axis_tdata[i*CW +: CW];
      src[i] = s_axis_tdata[(3+i)*CW +: CW];
    end
    s_axis_tready = !st.busy;
    start         = s_axis_tvalid && s_axis_tready;
    out_free      = !m_axis_tvalid || m_axis_tready;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      softening_sq <= '0;
    end else if (cfg_wr_en) begin
      softening_sq <= cfg_wr_data;
    end
  end

  sga_core #(.CW(CW), .SW(SUM_WIDTH)) u_core (
    .clk(clk), .rst(rst), .start(start),
    .tgt(tgt), .src(src),
    .mass_in(s_axis_tdata[6*CW +: MASS_W]),
    .first_in(s_axis_tuser), .last_in(s_axis_tlast),
    .softening_sq(softening_sq), .out_free(out_free),
    .status(st), .sum_x(sx), .sum_y(sy), .sum_z(sz)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (st.done && st.last && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st.done && st.last && out_free) begin
      m_axis_tdata <= {ACC_W'(sz), ACC_W'(sy), ACC_W'(sx)};
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("core took an item without going busy");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    st.done && st.last && !out_free |=> st.done)
    else $error("result dropped while output register full");
  a_load_only_on_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(st.done && st.last))
    else $error("output valid without a finished last item");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for softened_gravity_accumulator: streams target/source items and checks
// the emitted acceleration sums against a bit-exact predictor held in a scoreboard.
// Depends on sga_pkg and the softened_gravity_accumulator RTL.
module tb;
  import sga_pkg::*;

  typedef struct {
    logic signed [31:0] tgt_x, tgt_y, tgt_z;
    logic signed [31:0] src_x, src_y, src_z;
    logic [31:0] mass;
    logic first, last;
  } body_item_t;

  typedef struct {
    logic signed [63:0] ax, ay, az;
  } accel_t;

  // Predicts the accumulated acceleration and checks emitted sums in order
  class accel_scoreboard;
    logic [31:0] soft_sq;
    logic signed [63:0] sum[3];
    accel_t pending_q[$];
    int errors;

    function new();
      soft_sq = 0;
      sum = '{0, 0, 0};
      errors = 0;
    endfunction

    // one Plummer term plus saturating add per axis; queues the sums on last
    function void note_item(body_item_t it);
      logic signed [32:0] d[3];
      logic [32:0] ad[3];
      logic [127:0] r2, cc, c;
      logic [63:0] root;
      logic [191:0] den, num, quo;
      logic signed [63:0] term;
      logic signed [64:0] tot;
      logic [63:0] cap;
      accel_t res;
      cap = {1'b0, {63{1'b1}}};
      if (it.first) sum = '{0, 0, 0};
      d[0] = {it.src_x[31], it.src_x} - {it.tgt_x[31], it.tgt_x};
      d[1] = {it.src_y[31], it.src_y} - {it.tgt_y[31], it.tgt_y};
      d[2] = {it.src_z[31], it.src_z} - {it.tgt_z[31], it.tgt_z};
      r2 = 128'(soft_sq) << EPS_SH;
      for (int i = 0; i < 3; i++) begin
        ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
        r2 += 128'(ad[i]) * 128'(ad[i]);
      end
      // zero softened distance contributes nothing
      if (r2 != 0) begin
        root = 0;
        for (int b = 63; b >= 0; b--) begin
          c = 128'(root | (64'd1 << b));
          cc = c * c;
          if (cc <= r2) root = c[63:0];
        end
        den = 192'(r2) * 192'(root);
        for (int i = 0; i < 3; i++) begin
          term = 0;
          if (ad[i] != 0 && it.mass != 0) begin
            num = (192'(it.mass) * 192'(ad[i])) << FRAC_SH;
            quo = num / den;
            term = (quo > 192'(cap)) ? cap : quo[63:0];
            if (d[i][32]) term = -term;
          end
          tot = 65'(sum[i]) + 65'(term);
          if (tot > 65'sh0_7FFF_FFFF_FFFF_FFFF) sum[i] = 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (tot < -65'sh0_8000_0000_0000_0000) sum[i] = 64'sh8000_0000_0000_0000;
          else sum[i] = tot[63:0];
        end
      end
      if (it.last) begin
        res.ax = sum[0];
        res.ay = sum[1];
        res.az = sum[2];
        pending_q.push_back(res);
      end
    endfunction

    function void check_result(logic [191:0] data);
      accel_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (data[63:0] !== want.ax) begin
        $display("%0t: acc_x expected %h actual %h", $time, want.ax, data[63:0]);
        errors++;
      end
      if (data[127:64] !== want.ay) begin
        $display("%0t: acc_y expected %h actual %h", $time, want.ay, data[127:64]);
        errors++;
      end
      if (data[191:128] !== want.az) begin
        $display("%0t: acc_z expected %h actual %h", $time, want.az, data[191:128]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [223:0] s_axis_tdata = 0;
  logic s_axis_tuser = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [191:0] m_axis_tdata;

  accel_scoreboard sb;
  bit no_idle = 0;
  int sent = 0;

  softened_gravity_accumulator uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side: random stalls, checked at the rising edge
  always @(negedge clk) m_axis_tready <= no_idle || ($urandom_range(99) >= 38);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task send_body(body_item_t it);
    while (!no_idle && $urandom_range(99) < 38) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tdata = {it.mass, it.src_z, it.src_y, it.src_x, it.tgt_z, it.tgt_y, it.tgt_x};
    s_axis_tuser = it.first;
    s_axis_tlast = it.last;
    s_axis_tvalid = 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(it);
    sent++;
    @(negedge clk);
  endtask

  // wait for every sum, then for any run still in flight
  task drain;
    s_axis_tvalid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task write_soft(logic [31:0] v);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    sb.soft_sq = v;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  function logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($signed($urandom_range(40000)) - 20000);
    endcase
  endfunction

  function body_item_t body(logic [31:0] tx, ty, tz, sx, sy, sz, m, logic f, l);
    body_item_t it;
    it.tgt_x = tx; it.tgt_y = ty; it.tgt_z = tz;
    it.src_x = sx; it.src_y = sy; it.src_z = sz;
    it.mass = m; it.first = f; it.last = l;
    return it;
  endfunction

  // runs with random content; some items get a random first or last flag
  task random_runs(int count);
    body_item_t it;
    int len, stop_at;
    logic [31:0] tx, ty, tz;
    stop_at = sent + count;
    while (sent < stop_at) begin
      len = $urandom_range(6, 1);
      tx = rand_coord(); ty = rand_coord(); tz = rand_coord();
      for (int k = 0; k < len; k++) begin
        it = body(tx, ty, tz, rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 20),
                  k == 0, k == len - 1);
        if ($urandom_range(9) == 0) it.first = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) it.last = 1'($urandom_range(1));
        send_body(it);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero softening, extremes and the special cases
    write_soft(32'd0);
    send_body(body(5, 6, 7, 5, 6, 7, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_body(body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_body(body(32'h7FFF_FFFF, 0, 32'h8000_0000,
                   32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1, 1'b1));
    send_body(body(0, 0, 0, 32'h10000, 0, 0, 0, 1'b1, 1'b1));
    send_body(body(0, 0, 0, 32'h10000, 32'h20000, 32'hFFFF_0000, 32'h10000, 1'b0, 1'b1));
    send_body(body(0, 0, 0, 32'h30000, 32'hFFFE_0000, 32'h1000, 32'h50000, 1'b0, 1'b0));
    send_body(body(0, 0, 0, 32'hFFFF_0000, 32'h8000, 32'h40000, 32'h20000, 1'b0, 1'b1));
    // positive then negative saturation
    send_body(body(0, 0, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_body(body(0, 0, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_body(body(0, 0, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_body(body(9, 9, 9, 8, 8, 8, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_body(body(9, 9, 9, 8, 8, 8, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_body(body(1, 1, 1, 1, 1, 1, 32'h10000, 1'b0, 1'b1));
    random_runs(100);
    drain();

    write_soft(32'hFFFF_FFFF);
    send_body(body(3, 3, 3, 3, 3, 3, 32'hFFFF_FFFF, 1'b1, 1'b1));
    random_runs(110);
    drain();

    write_soft($urandom);
    no_idle = 1;
    random_runs(110);
    drain();

    no_idle = 0;
    write_soft(32'h0001_0000);
    random_runs(110);
    drain();

    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
